// ----- sv/sct_pkg.sv -----
// shared types, codes and character constants of the command tokenizer
`default_nettype none
package sct_pkg;

  localparam int COUNT_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH = 4;

  // results per item and the width of a result count (one more than fits)
  localparam int NSLOT = 4;
  localparam int SLOT_W = $clog2(NSLOT);
  localparam int N_W = SLOT_W + 1;

  // result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_SUM  = 2'd2;

  // pending lookahead codes
  localparam logic [2:0] PEND_NONE   = 3'd0;
  localparam logic [2:0] PEND_AMP    = 3'd1;
  localparam logic [2:0] PEND_PIPE   = 3'd2;
  localparam logic [2:0] PEND_GT     = 3'd3;
  localparam logic [2:0] PEND_DOT    = 3'd4;
  localparam logic [2:0] PEND_ESC    = 3'd5;
  localparam logic [2:0] PEND_ESC_DQ = 3'd6;

  // flag bit positions
  localparam int FB_CHAIN = 0;
  localparam int FB_PIPE  = 1;
  localparam int FB_SUB   = 2;
  localparam int FB_REDIR = 3;

  localparam logic [7:0] CH_SQ     = 8'h27;
  localparam logic [7:0] CH_DQ     = 8'h22;
  localparam logic [7:0] CH_BT     = 8'h60;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] ASCII_MAX = 8'd127;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] char_in;
    logic       end_of_command;
  } sct_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  token_byte;
    logic        chain_flag;
    logic        pipe_flag;
    logic        subshell_flag;
    logic        redirect_flag;
    logic [15:0] token_total;
    logic        last_of_run;
  } sct_out_t;

  // all results of one item, in order, with the index of the last one
  typedef struct packed {
    logic [SLOT_W-1:0]          last_idx;
    sct_out_t [NSLOT-1:0]       res;
  } sct_bundle_t;

  typedef struct packed {
    logic       in_single;
    logic       in_double;
    logic       saw_quotes;
    logic       expr_start;
    logic       token_open;
    logic [2:0] pend;
    logic [3:0] flags;
  } sct_state_t;

  localparam sct_state_t ST_RESET = '{
    in_single:  1'b0,
    in_double:  1'b0,
    saw_quotes: 1'b0,
    expr_start: 1'b1,
    token_open: 1'b0,
    pend:       PEND_NONE,
    flags:      4'b0
  };

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage
`default_nettype wire

// ----- sv/sct_front.sv -----
// front part: takes one byte item, updates tokenizer state, builds its results
`default_nettype none
module sct_front
  import sct_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire sct_in_t     item_i,
  input  wire logic        q_full_i,
  output logic             q_wr_o,
  output sct_bundle_t      q_data_o
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam int TW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  sct_state_t st_q, st_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic accept;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // results past the last slot are dropped
  function automatic sct_bundle_t put(input sct_bundle_t b, input logic [N_W-1:0] n,
                                      input logic [1:0] k, input logic [7:0] byt);
    sct_bundle_t r;
    r = b;
    if (int'(n) < NSLOT) begin
      r.res[n[SLOT_W-1:0]].kind = k;
      r.res[n[SLOT_W-1:0]].token_byte = byt;
    end
    return r;
  endfunction

  assign accept = push_i && !q_full_i;

  always_comb begin
    sct_state_t s;
    logic [COUNT_BITS-1:0] cnt;
    sct_bundle_t b;
    logic [N_W-1:0] n;
    logic [N_W-1:0] n_m1;
    logic [SLOT_W-1:0] idx;
    logic [2:0] k;
    logic consumed;
    logic [7:0] c;
    logic [TW-1:0] tot_w;

    s = st_q;
    cnt = cnt_q;
    b = '0;
    n = '0;
    k = PEND_NONE;
    consumed = 1'b0;
    c = item_i.char_in;

    if (item_i.has_byte) begin
      if (s.pend != PEND_NONE) begin
        k = s.pend;
        s.pend = PEND_NONE;
        case (k)
          PEND_AMP: begin
            if (c == CH_AMP) begin
              s.flags[FB_CHAIN] = 1'b1;
              s.expr_start = 1'b1;
              consumed = 1'b1;
            end else if (s.expr_start) begin
              s.flags[FB_SUB] = 1'b1;
            end else begin
              s.flags[FB_CHAIN] = 1'b1;
            end
          end
          PEND_PIPE: begin
            if (c == CH_PIPE) begin
              s.flags[FB_CHAIN] = 1'b1;
              consumed = 1'b1;
            end else begin
              s.flags[FB_PIPE] = 1'b1;
            end
          end
          PEND_GT: begin
            consumed = (c == CH_GT);
          end
          PEND_DOT: begin
            if (c == CH_SPACE || c == CH_TAB) begin
              s.flags[FB_SUB] = 1'b1;
              if (s.token_open) begin
                b = put(b, n, KIND_END, 8'h00);
                n = n + 1'b1;
                cnt = sat_inc(cnt);
                s.token_open = 1'b0;
              end
            end else begin
              b = put(b, n, KIND_BYTE, CH_DOT);
              n = n + 1'b1;
              s.token_open = 1'b1;
              s.expr_start = 1'b0;
            end
          end
          PEND_ESC, PEND_ESC_DQ: begin
            // escaped byte goes in literally, no non-ascii check
            b = put(b, n, KIND_BYTE, c);
            n = n + 1'b1;
            s.token_open = 1'b1;
            consumed = 1'b1;
          end
          default: begin
          end
        endcase
      end

      if (!consumed) begin
        if (c > ASCII_MAX) s.flags[FB_CHAIN] = 1'b1;
        if (c == CH_SQ && !s.in_double) begin
          s.in_single = !s.in_single;
          s.saw_quotes = 1'b1;
          s.expr_start = 1'b0;
        end else if (c == CH_DQ && !s.in_single) begin
          s.in_double = !s.in_double;
          s.saw_quotes = 1'b1;
          s.expr_start = 1'b0;
        end else if (s.in_single) begin
          b = put(b, n, KIND_BYTE, c);
          n = n + 1'b1;
          s.token_open = 1'b1;
        end else if (s.in_double) begin
          if (c == CH_BT) begin
            s.pend = PEND_ESC_DQ;
          end else begin
            if (c == CH_DOLLAR) s.flags[FB_SUB] = 1'b1;
            b = put(b, n, KIND_BYTE, c);
            n = n + 1'b1;
            s.token_open = 1'b1;
          end
        end else if (is_space(c)) begin
          // quotes keep the token alive until whitespace
          if (s.token_open || s.saw_quotes) begin
            b = put(b, n, KIND_END, 8'h00);
            n = n + 1'b1;
            cnt = sat_inc(cnt);
            s.token_open = 1'b0;
            s.saw_quotes = 1'b0;
          end
          s.expr_start = 1'b1;
        end else if (c == CH_BT) begin
          s.flags[FB_CHAIN] = 1'b1;
          s.expr_start = 1'b0;
          s.pend = PEND_ESC;
        end else if (c == CH_AMP) begin
          if (s.token_open) begin
            b = put(b, n, KIND_END, 8'h00);
            n = n + 1'b1;
            cnt = sat_inc(cnt);
            s.token_open = 1'b0;
          end
          s.pend = PEND_AMP;
        end else if (c == CH_DOT && s.expr_start) begin
          s.pend = PEND_DOT;
        end else if (c == CH_SEMI || c == CH_PIPE || c == CH_LPAR || c == CH_RPAR ||
                     c == CH_LBRACE || c == CH_RBRACE || c == CH_DOLLAR ||
                     c == CH_GT || c == CH_LT) begin
          s.expr_start = 1'b0;
          if (c == CH_SEMI) s.flags[FB_CHAIN] = 1'b1;
          else if (c == CH_GT || c == CH_LT) s.flags[FB_REDIR] = 1'b1;
          else if (c != CH_PIPE) s.flags[FB_SUB] = 1'b1;
          if (s.token_open) begin
            b = put(b, n, KIND_END, 8'h00);
            n = n + 1'b1;
            cnt = sat_inc(cnt);
            s.token_open = 1'b0;
          end
          if (c == CH_PIPE) s.pend = PEND_PIPE;
          else if (c == CH_GT) s.pend = PEND_GT;
        end else begin
          b = put(b, n, KIND_BYTE, c);
          n = n + 1'b1;
          s.token_open = 1'b1;
          s.expr_start = 1'b0;
        end
      end
    end

    if (item_i.end_of_command) begin
      k = s.pend;
      s.pend = PEND_NONE;
      if (k == PEND_AMP) begin
        if (s.expr_start) s.flags[FB_SUB] = 1'b1;
        else s.flags[FB_CHAIN] = 1'b1;
      end else if (k == PEND_PIPE) begin
        s.flags[FB_PIPE] = 1'b1;
      end else if (k == PEND_DOT) begin
        b = put(b, n, KIND_BYTE, CH_DOT);
        n = n + 1'b1;
        s.token_open = 1'b1;
      end else if (k == PEND_ESC_DQ) begin
        // trailing backtick inside double quotes is a literal byte
        b = put(b, n, KIND_BYTE, CH_BT);
        n = n + 1'b1;
        s.token_open = 1'b1;
      end
      if (s.in_single || s.in_double) s.flags[FB_CHAIN] = 1'b1;
      if (s.token_open || s.saw_quotes) begin
        b = put(b, n, KIND_END, 8'h00);
        n = n + 1'b1;
        cnt = sat_inc(cnt);
      end
      b = put(b, n, KIND_SUM, 8'h00);
      n = n + 1'b1;
    end

    n_m1 = n - 1'b1;
    idx = (int'(n) > NSLOT) ? SLOT_W'(NSLOT - 1) : n_m1[SLOT_W-1:0];
    tot_w = TW'(cnt);
    b.last_idx = idx;
    if (n != '0) b.res[idx].last_of_run = 1'b1;
    // summary fields land on the last kept result
    if (item_i.end_of_command) begin
      b.res[idx].chain_flag    = s.flags[FB_CHAIN];
      b.res[idx].pipe_flag     = s.flags[FB_PIPE];
      b.res[idx].subshell_flag = s.flags[FB_SUB];
      b.res[idx].redirect_flag = s.flags[FB_REDIR];
      b.res[idx].token_total   = tot_w[15:0];
      s = ST_RESET;
      cnt = '0;
    end

    st_d = s;
    cnt_d = cnt;
    q_data_o = b;
    q_wr_o = accept && (n != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_RESET;
      cnt_q <= '0;
    end else if (accept) begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ----- sv/sct_queue.sv -----
// short register queue of result bundles between front and back parts
`default_nettype none
module sct_queue
  import sct_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH,
  parameter int WIDTH = $bits(sct_bundle_t)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  output logic                  full_o,
  input  wire logic             rd_i,
  output logic [WIDTH-1:0]      rd_data_o,
  output logic                  empty_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic do_wr, do_rd;

  assign full_o    = (cnt_q == CW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rp_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;

  always_comb begin
    wp_d  = do_wr ? ((wp_q == PTR_LAST) ? '0 : wp_q + 1'b1) : wp_q;
    rp_d  = do_rd ? ((rp_q == PTR_LAST) ? '0 : rp_q + 1'b1) : rp_q;
    cnt_d = cnt_q + CW'(do_wr) - CW'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule
`default_nettype wire

// ----- sv/sct_back.sv -----
// back part: hands out the results of the oldest bundle one at a time
`default_nettype none
module sct_back
  import sct_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire sct_bundle_t q_data_i,
  input  wire logic        q_empty_i,
  output logic             q_rd_o,
  input  wire logic        pop,
  output logic             empty,
  output sct_out_t         result_o
);

  logic [SLOT_W-1:0] sub_q, sub_d;
  logic take;

  assign empty    = q_empty_i;
  assign result_o = q_data_i.res[sub_q];
  assign take     = pop && !q_empty_i;

  always_comb begin
    sub_d  = sub_q;
    q_rd_o = 1'b0;
    if (take) begin
      // retire the bundle after its last result
      if (sub_q == q_data_i.last_idx) begin
        sub_d  = '0;
        q_rd_o = 1'b1;
      end else begin
        sub_d = sub_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= '0;
    end else begin
      sub_q <= sub_d;
    end
  end

endmodule
`default_nettype wire

// ----- sv/shell_command_tokenizer.sv -----
// Command line tokenizer, top level.
// Input side is a queue: drive item_i and raise push; the byte is taken at a
// rising edge with push high and full low. Each item carries one byte of the
// command line (or none, for a bare end) and an end_of_command mark.
// Result side is a queue too: while empty is low the oldest result sits on
// result_o and is taken at an edge with pop high. An item gives zero to four
// results (token bytes, token ends, and on the item with the end mark the summary
// with the flags and token count); last_of_run marks the final one of an item.
// Results of an item go into the queue when it is taken and show on result_o
// once the results ahead are taken. Throughput: one item per cycle while full
// is low, set by the combinational classify logic of the front part; the result
// side hands out one result per cycle while pop is high. A queue of QUEUE_DEPTH
// bundles sits between, so a stalled receiver only raises full once it fills.
// Reset clears the tokenizer state and the queue; empty goes high.
`default_nettype none
module shell_command_tokenizer
  import sct_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT,
  parameter int DEPTH      = QUEUE_DEPTH
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output logic          full,
  input  wire sct_in_t  item_i,
  output logic          empty,
  input  wire logic     pop,
  output sct_out_t      result_o
);

  logic        q_wr, q_rd, q_empty;
  sct_bundle_t q_wdata, q_rdata;

  sct_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (item_i),
    .q_full_i (full),
    .q_wr_o   (q_wr),
    .q_data_o (q_wdata)
  );

  sct_queue #(
    .DEPTH(DEPTH),
    .WIDTH($bits(sct_bundle_t))
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wdata),
    .full_o    (full),
    .rd_i      (q_rd),
    .rd_data_o (q_rdata),
    .empty_o   (q_empty)
  );

  sct_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_data_i  (q_rdata),
    .q_empty_i (q_empty),
    .q_rd_o    (q_rd),
    .pop       (pop),
    .empty     (empty),
    .result_o  (result_o)
  );

endmodule
`default_nettype wire

// ----- sv/sct_checker.sv -----
// port-level checks of the tokenizer, bound to the top level
`default_nettype none
module sct_checker
  import sct_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     push,
  input wire logic     full,
  input wire sct_in_t  item_i,
  input wire logic     empty,
  input wire logic     pop,
  input wire sct_out_t result_o
);

  // a summary always closes its item
  a_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.kind == KIND_SUM) |-> result_o.last_of_run)
    else $error("summary result without last_of_run");

  // only token byte results carry a byte
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.kind != KIND_BYTE) |-> (result_o.token_byte == 8'h00))
    else $error("non-byte result carries a byte");

  // a command end always produces at least the summary
  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && item_i.end_of_command) |=> !empty)
    else $error("command end gave no result");

  // a waiting result holds while the receiver stalls
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("stalled result changed");

endmodule

bind shell_command_tokenizer sct_checker u_sct_checker (.*);
`default_nettype wire

// ----- tb/sv/tb_shell_command_tokenizer.sv -----
// self-checking testbench of the command line tokenizer: directed table, then random lines
`timescale 1ns / 100ps
module tb_shell_command_tokenizer;
  import sct_pkg::*;

  localparam logic [15:0] TOKEN_CAP = 16'hFFFF;
  localparam int RANDOM_ITEMS = 230;
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    sct_in_t  item;
    logic     typed;
    sct_out_t want;
  } dir_row_t;

  localparam sct_out_t NO_WANT = '0;
  localparam sct_out_t SUM_EMPTY = '{KIND_SUM, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1};
  localparam sct_out_t BYTE_ZERO = '{KIND_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1};

  // short directed command lines; only the obvious rows carry a typed result
  dir_row_t dir_plan [25] = '{
    '{'{1'b0, 8'h00, 1'b1}, 1'b1, SUM_EMPTY},  // empty command
    '{'{1'b0, 8'hFF, 1'b0}, 1'b0, NO_WANT},    // ignored item
    '{'{1'b1, 8'h00, 1'b0}, 1'b1, BYTE_ZERO},  // zero byte is a plain byte
    '{'{1'b1, 8'hFF, 1'b1}, 1'b0, NO_WANT},
    '{'{1'b1, CH_DQ, 1'b0}, 1'b0, NO_WANT},    // empty quoted token
    '{'{1'b1, CH_DQ, 1'b0}, 1'b0, NO_WANT},
    '{'{1'b1, CH_SPACE, 1'b0}, 1'b0, NO_WANT},
    '{'{1'b1, CH_DQ, 1'b0}, 1'b0, NO_WANT},    // escaped non-ascii inside quotes
    '{'{1'b1, CH_BT, 1'b0}, 1'b0, NO_WANT},
    '{'{1'b1, 8'hC8, 1'b0}, 1'b0, NO_WANT},
    '{'{1'b1, CH_DQ, 1'b0}, 1'b0, NO_WANT},
    '{'{1'b0, 8'h5A, 1'b1}, 1'b0, NO_WANT},
    '{'{1'b1, CH_DQ, 1'b0}, 1'b0, NO_WANT},    // trailing backtick inside quotes
    '{'{1'b1, CH_BT, 1'b1}, 1'b0, NO_WANT},
    '{'{1'b1, CH_DOT, 1'b0}, 1'b0, NO_WANT},   // dot-source
    '{'{1'b1, CH_SPACE, 1'b0}, 1'b0, NO_WANT},
    '{'{1'b1, CH_AMP, 1'b0}, 1'b0, NO_WANT},
    '{'{1'b1, CH_AMP, 1'b0}, 1'b0, NO_WANT},
    '{'{1'b1, CH_PIPE, 1'b0}, 1'b0, NO_WANT},
    '{'{1'b1, 8'h78, 1'b0}, 1'b0, NO_WANT},
    '{'{1'b1, CH_GT, 1'b0}, 1'b0, NO_WANT},
    '{'{1'b1, CH_GT, 1'b0}, 1'b0, NO_WANT},
    '{'{1'b1, CH_BT, 1'b1}, 1'b0, NO_WANT},    // line continuation
    '{'{1'b1, CH_SQ, 1'b0}, 1'b0, NO_WANT},
    '{'{1'b1, CH_SQ, 1'b1}, 1'b0, NO_WANT}
  };

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     push = 1'b0;
  logic     pop = 1'b0;
  sct_in_t  item_i = '0;
  logic     full;
  logic     empty;
  sct_out_t result_o;

  // tokenizer state as predicted
  logic        tk_single, tk_double, tk_quotes, tk_expr, tk_open;
  logic [2:0]  tk_pend;
  logic [3:0]  tk_flags;
  logic [15:0] tk_count;

  sct_out_t item_res [NSLOT];
  int       item_nres;
  sct_out_t expected_results [$];
  logic [7:0] line_q [$];

  int n_errors = 0;
  int n_random = 0;
  bit steady = 1'b0;
  bit random_phase = 1'b0;
  bit squeeze = 1'b0;
  bit held = 1'b0;

  shell_command_tokenizer dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void clear_state();
    tk_single = 1'b0;
    tk_double = 1'b0;
    tk_quotes = 1'b0;
    tk_expr = 1'b1;
    tk_open = 1'b0;
    tk_pend = PEND_NONE;
    tk_flags = '0;
    tk_count = '0;
  endfunction

  // at most NSLOT results per item, further ones are dropped
  function automatic void put_result(logic [1:0] k, logic [7:0] b);
    if (item_nres < NSLOT) begin
      item_res[item_nres] = '0;
      item_res[item_nres].kind = k;
      item_res[item_nres].token_byte = b;
      item_nres++;
    end
  endfunction

  function automatic void add_byte(logic [7:0] c);
    put_result(KIND_BYTE, c);
    tk_open = 1'b1;
  endfunction

  function automatic void close_token();
    put_result(KIND_END, 8'h00);
    if (tk_count < TOKEN_CAP) tk_count++;
    tk_open = 1'b0;
  endfunction

  function automatic bit blank(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void take_plain(logic [7:0] c);
    if (c > ASCII_MAX) tk_flags[FB_CHAIN] = 1'b1;
    if (c == CH_SQ && !tk_double) begin
      tk_single = !tk_single;
      tk_quotes = 1'b1;
      tk_expr = 1'b0;
      return;
    end
    if (c == CH_DQ && !tk_single) begin
      tk_double = !tk_double;
      tk_quotes = 1'b1;
      tk_expr = 1'b0;
      return;
    end
    if (tk_single) begin
      add_byte(c);
      return;
    end
    if (tk_double) begin
      if (c == CH_BT) begin
        tk_pend = PEND_ESC_DQ;
        return;
      end
      if (c == CH_DOLLAR) tk_flags[FB_SUB] = 1'b1;
      add_byte(c);
      return;
    end
    if (blank(c)) begin
      // quotes alone still make a token; the mark is cleared here or at command end
      if (tk_open || tk_quotes) begin
        close_token();
        tk_quotes = 1'b0;
      end
      tk_expr = 1'b1;
      return;
    end
    if (c == CH_BT) begin
      tk_flags[FB_CHAIN] = 1'b1;
      tk_expr = 1'b0;
      tk_pend = PEND_ESC;
      return;
    end
    if (c == CH_AMP) begin
      if (tk_open) close_token();
      tk_pend = PEND_AMP;
      return;
    end
    if (c == CH_DOT && tk_expr) begin
      tk_pend = PEND_DOT;
      return;
    end
    case (c)
      CH_SEMI, CH_PIPE, CH_LPAR, CH_RPAR, CH_LBRACE, CH_RBRACE, CH_DOLLAR, CH_GT,
      CH_LT: begin
        tk_expr = 1'b0;
        if (c == CH_SEMI) tk_flags[FB_CHAIN] = 1'b1;
        else if (c == CH_GT || c == CH_LT) tk_flags[FB_REDIR] = 1'b1;
        else if (c != CH_PIPE) tk_flags[FB_SUB] = 1'b1;
        if (tk_open) close_token();
        if (c == CH_PIPE) tk_pend = PEND_PIPE;
        else if (c == CH_GT) tk_pend = PEND_GT;
        return;
      end
      default: ;
    endcase
    add_byte(c);
    tk_expr = 1'b0;
  endfunction

  // settle a held operator with the next byte; 1 if the byte is used up
  function automatic bit take_lookahead(logic [7:0] c);
    logic [2:0] k;
    k = tk_pend;
    tk_pend = PEND_NONE;
    case (k)
      PEND_AMP: begin
        if (c == CH_AMP) begin
          tk_flags[FB_CHAIN] = 1'b1;
          tk_expr = 1'b1;
          return 1'b1;
        end
        if (tk_expr) tk_flags[FB_SUB] = 1'b1;
        else tk_flags[FB_CHAIN] = 1'b1;
        return 1'b0;
      end
      PEND_PIPE: begin
        if (c == CH_PIPE) begin
          tk_flags[FB_CHAIN] = 1'b1;
          return 1'b1;
        end
        tk_flags[FB_PIPE] = 1'b1;
        return 1'b0;
      end
      PEND_GT: return c == CH_GT;
      PEND_DOT: begin
        if (c == CH_SPACE || c == CH_TAB) begin
          tk_flags[FB_SUB] = 1'b1;
          if (tk_open) close_token();
        end else begin
          add_byte(CH_DOT);
          tk_expr = 1'b0;
        end
        return 1'b0;
      end
      PEND_ESC, PEND_ESC_DQ: begin
        add_byte(c);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void settle_at_end();
    logic [2:0] k;
    k = tk_pend;
    tk_pend = PEND_NONE;
    if (k == PEND_AMP) begin
      if (tk_expr) tk_flags[FB_SUB] = 1'b1;
      else tk_flags[FB_CHAIN] = 1'b1;
    end else if (k == PEND_PIPE) begin
      tk_flags[FB_PIPE] = 1'b1;
    end else if (k == PEND_DOT) begin
      add_byte(CH_DOT);
      tk_expr = 1'b0;
    end else if (k == PEND_ESC_DQ) begin
      add_byte(CH_BT);
    end
  endfunction

  // results of one accepted item, left in item_res
  function automatic void forecast_item(sct_in_t it);
    bit used;
    item_nres = 0;
    used = 1'b0;
    if (it.has_byte) begin
      if (tk_pend != PEND_NONE) used = take_lookahead(it.char_in);
      if (!used) take_plain(it.char_in);
    end
    if (it.end_of_command) begin
      settle_at_end();
      if (tk_single || tk_double) tk_flags[FB_CHAIN] = 1'b1;
      if (tk_open || tk_quotes) close_token();
      put_result(KIND_SUM, 8'h00);
      item_res[item_nres-1].chain_flag = tk_flags[FB_CHAIN];
      item_res[item_nres-1].pipe_flag = tk_flags[FB_PIPE];
      item_res[item_nres-1].subshell_flag = tk_flags[FB_SUB];
      item_res[item_nres-1].redirect_flag = tk_flags[FB_REDIR];
      item_res[item_nres-1].token_total = tk_count;
      clear_state();
    end
    if (item_nres > 0) item_res[item_nres-1].last_of_run = 1'b1;
  endfunction

  // mostly back to back, sometimes a short gap, rarely a long pause
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  task automatic send_item(sct_in_t it, bit typed, sct_out_t want);
    int gap;
    item_i <= it;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    forecast_item(it);
    if (typed) begin
      expected_results.push_back(want);
    end else begin
      for (int i = 0; i < item_nres; i++) expected_results.push_back(item_res[i]);
    end
    gap = (steady || squeeze) ? 0 : gap_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [7:0] letter();
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  // one command line: words, blanks, operators, quotes and escapes, or raw noise
  task automatic make_line();
    line_q.delete();
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 10)) line_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: repeat ($urandom_range(1, 4)) line_q.push_back(letter());
        3: repeat ($urandom_range(1, 2)) begin
          if ($urandom_range(0, 3) == 0) line_q.push_back(8'($urandom_range(9, 13)));
          else line_q.push_back(CH_SPACE);
        end
        4: case ($urandom_range(0, 13))
          0: begin line_q.push_back(CH_AMP); line_q.push_back(CH_AMP); end
          1: begin line_q.push_back(CH_PIPE); line_q.push_back(CH_PIPE); end
          2: line_q.push_back(CH_PIPE);
          3: line_q.push_back(CH_GT);
          4: begin line_q.push_back(CH_GT); line_q.push_back(CH_GT); end
          5: line_q.push_back(CH_LT);
          6: line_q.push_back(CH_SEMI);
          7: line_q.push_back(CH_LPAR);
          8: line_q.push_back(CH_RPAR);
          9: line_q.push_back(CH_LBRACE);
          10: line_q.push_back(CH_RBRACE);
          11: line_q.push_back(CH_DOLLAR);
          12: line_q.push_back(CH_AMP);
          default: begin line_q.push_back(CH_DOT); line_q.push_back(CH_SPACE); end
        endcase
        5: begin
          line_q.push_back(CH_DQ);
          repeat ($urandom_range(0, 4)) case ($urandom_range(0, 4))
            0: line_q.push_back(letter());
            1: line_q.push_back(CH_DOLLAR);
            2: begin
              line_q.push_back(CH_BT);
              line_q.push_back(8'($urandom_range(0, 255)));
            end
            3: line_q.push_back(CH_SQ);
            default: line_q.push_back(8'($urandom_range(0, 255)));
          endcase
          // now and then the quote stays open
          if ($urandom_range(0, 7) != 0) line_q.push_back(CH_DQ);
        end
        6: begin
          line_q.push_back(CH_SQ);
          repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 3) == 0) line_q.push_back(8'($urandom_range(0, 255)));
            else line_q.push_back(letter());
          end
          if ($urandom_range(0, 7) != 0) line_q.push_back(CH_SQ);
        end
        7: begin
          line_q.push_back(CH_BT);
          line_q.push_back(8'($urandom_range(0, 255)));
        end
        8: begin
          line_q.push_back(CH_DOT);
          if ($urandom_range(0, 1) == 0) line_q.push_back(letter());
        end
        default: line_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  task automatic check_result(sct_out_t got);
    sct_out_t want;
    if (expected_results.size() == 0) begin
      $error("result with nothing expected: kind %0d byte %0h", got.kind, got.token_byte);
      n_errors++;
      return;
    end
    want = expected_results.pop_front();
    cmp_field("kind", want.kind, got.kind);
    cmp_field("token_byte", want.token_byte, got.token_byte);
    cmp_field("chain_flag", want.chain_flag, got.chain_flag);
    cmp_field("pipe_flag", want.pipe_flag, got.pipe_flag);
    cmp_field("subshell_flag", want.subshell_flag, got.subshell_flag);
    cmp_field("redirect_flag", want.redirect_flag, got.redirect_flag);
    cmp_field("token_total", want.token_total, got.token_total);
    cmp_field("last_of_run", want.last_of_run, got.last_of_run);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) check_result(result_o);
  end

  // receiver: bursts of pops with random gaps, and one long hold to fill the block
  initial begin : drain
    int n;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (random_phase && !held) begin
        pop <= 1'b0;
        squeeze = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        squeeze = 1'b0;
        held = 1'b1;
      end else begin
        pop <= 1'b1;
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
        repeat (n) @(posedge clk_i);
        n = gap_len();
        if (n > 0) begin
          pop <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
      end
    end
  end

  initial begin : stim
    sct_in_t it;
    bit bare_end;
    clear_state();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_plan[i]) send_item(dir_plan[i].item, dir_plan[i].typed, dir_plan[i].want);

    random_phase = 1'b1;
    while (n_random < RANDOM_ITEMS) begin
      make_line();
      steady = ($urandom_range(0, 3) == 0);
      bare_end = (line_q.size() == 0) || ($urandom_range(0, 5) == 0);
      foreach (line_q[i]) begin
        // an ignored item now and then, in mid line
        if ($urandom_range(0, 19) == 0) begin
          it = '{1'b0, 8'($urandom_range(0, 255)), 1'b0};
          send_item(it, 1'b0, NO_WANT);
        end
        it = '{1'b1, line_q[i], (i == line_q.size() - 1) && !bare_end};
        send_item(it, 1'b0, NO_WANT);
        n_random++;
      end
      if (bare_end) begin
        it = '{1'b0, 8'($urandom_range(0, 255)), 1'b1};
        send_item(it, 1'b0, NO_WANT);
        n_random++;
      end
    end
    steady = 1'b0;
    push <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("tb_shell_command_tokenizer: clean");
    end else begin
      $display("tb_shell_command_tokenizer: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb_shell_command_tokenizer: errors");
    $finish;
  end

endmodule
